// ----- rtl/core/fwtm_pkg.sv -----
// shared types and constants for the fifo with type-matched dequeue
// no dependencies; imported by fwtm_cell and the top level
package fwtm_pkg;

    localparam int TAG_W  = 16;
    localparam int TYPE_W = 3;
    localparam int OCC_W  = 5;

    // operation codes carried in the request
    typedef enum logic [1:0] {
        OP_PUSH     = 2'd0,
        OP_POP      = 2'd1,
        OP_TYPE_POP = 2'd2,
        OP_NOP      = 2'd3
    } fwtm_op_t;

    // status codes carried in the result
    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_EMPTY   = 2'd2,
        STAT_NOMATCH = 2'd3
    } fwtm_status_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } fwtm_state_t;

    typedef struct packed {
        fwtm_op_t            op;
        logic [TAG_W-1:0]    item_tag;
        logic [TYPE_W-1:0]   item_type;
    } fwtm_in_t;

    typedef struct packed {
        fwtm_status_t        status;
        logic [TAG_W-1:0]    removed_tag;
        logic [TYPE_W-1:0]   removed_type;
        logic [OCC_W-1:0]    occupancy;
        logic                front_valid;
        logic [TAG_W-1:0]    front_tag;
    } fwtm_out_t;

    // one queue entry as held in a cell
    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [TYPE_W-1:0]   kind;
    } fwtm_entry_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic                load;
        logic                remove;
        logic                pop_any;
    } fwtm_cell_ctrl_t;

endpackage

// ----- rtl/core/fwtm_cell.sv -----
// one slot of the compacting queue: holds an entry, compares its type,
// and shifts in its right neighbor when an entry at or before it leaves
// depends on fwtm_pkg
module fwtm_cell (
    input  logic                      clk,
    input  fwtm_pkg::fwtm_cell_ctrl_t ctrl,
    input  logic                      occupied,
    input  logic [fwtm_pkg::TYPE_W-1:0] key_type,
    input  fwtm_pkg::fwtm_entry_t     load_data,
    input  fwtm_pkg::fwtm_entry_t     next_in,
    input  logic                      seen_in,
    output logic                      seen_out,
    input  fwtm_pkg::fwtm_entry_t     removed_in,
    output fwtm_pkg::fwtm_entry_t     removed_out,
    output fwtm_pkg::fwtm_entry_t     entry
);
    import fwtm_pkg::*;

    fwtm_entry_t entry_reg;
    logic        match;
    logic        take;

    // type compare; a plain pop matches any occupied slot
    assign match = occupied & (ctrl.pop_any | (entry_reg.kind == key_type));
    assign take  = match & ~seen_in;

    // first-match chain and removed-entry chain toward the rear
    assign seen_out    = seen_in | match;
    assign removed_out = removed_in | (take ? entry_reg : '0);
    assign entry       = entry_reg;

    // load on push, close the gap on removal
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            entry_reg <= load_data;
        end
        else if (ctrl.remove && seen_out)
        begin
            entry_reg <= next_in;
        end
    end

endmodule

// ----- rtl/core/fifo_with_type_match_dequeue_unit.sv -----
// top level of the fifo with type-matched dequeue: sequencer, count and
// result register around a row of fwtm_cell slots
// depends on fwtm_pkg and fwtm_cell
//
// usage
//   request channel: drive req and raise start; the transfer happens at a
//   rising edge with start high and busy low. ops are push at rear, pop
//   front, pop oldest entry of a type, and a no-op code.
//   result channel: done is high for exactly one cycle with result valid;
//   the result must be taken in that cycle, there is no back-pressure.
// sequence
//   a request is executed in the cycle after its transfer (busy high),
//   and its result shows in the cycle after that with done. the next
//   request can transfer while that result is shown. the registered
//   request is followed by the type compare, first-match chain and
//   compaction across the cells, all done in the execute cycle.
// reset
//   rst_n clears the entry count, the sequencer and done; slot contents
//   are left as they are and are never read before being written.
module fifo_with_type_match_dequeue_unit #(
    parameter int DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  fwtm_pkg::fwtm_in_t req,
    output logic               done,
    output fwtm_pkg::fwtm_out_t result
);
    import fwtm_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    fwtm_state_t     state_reg, state_next;
    fwtm_in_t        req_reg, req_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic            done_reg, done_next;
    fwtm_out_t       result_reg, result_next;

    fwtm_cell_ctrl_t ctrl [DEPTH];
    logic            occupied [DEPTH];
    logic            seen [DEPTH+1];
    fwtm_entry_t     removed [DEPTH+1];
    fwtm_entry_t     entry [DEPTH];
    fwtm_entry_t     push_data;

    logic            exec;
    logic            full;
    logic            empty;
    logic            hit;
    logic            do_remove;
    logic            push_ok;

    assign exec      = (state_reg == ST_EXEC);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign hit       = seen[DEPTH];
    assign do_remove = exec & ((req_reg.op == OP_POP) | (req_reg.op == OP_TYPE_POP));
    assign push_ok   = exec & (req_reg.op == OP_PUSH) & ~full;
    assign push_data.tag  = req_reg.item_tag;
    assign push_data.kind = req_reg.item_type;

    assign seen[0]    = 1'b0;
    assign removed[0] = '0;

    // row of slots, front at index 0
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        fwtm_entry_t next_entry;

        if (i < DEPTH - 1)
        begin : g_mid
            assign next_entry = entry[i+1];
        end
        else
        begin : g_last
            assign next_entry = '0;
        end

        assign occupied[i]     = (CNT_W'(i) < count_reg);
        assign ctrl[i].load    = push_ok & (count_reg == CNT_W'(i));
        assign ctrl[i].remove  = do_remove;
        assign ctrl[i].pop_any = (req_reg.op == OP_POP);

        fwtm_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl[i]),
            .occupied    (occupied[i]),
            .key_type    (req_reg.item_type),
            .load_data   (push_data),
            .next_in     (next_entry),
            .seen_in     (seen[i]),
            .seen_out    (seen[i+1]),
            .removed_in  (removed[i]),
            .removed_out (removed[i+1]),
            .entry       (entry[i])
        );
    end

    // sequencer, count and result
    always_comb
    begin
        fwtm_status_t     stat;
        logic [TAG_W-1:0] front;

        state_next  = state_reg;
        req_next    = req_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        busy        = 1'b0;
        stat        = STAT_DONE;
        front       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                busy       = 1'b1;
                state_next = ST_IDLE;
                done_next  = 1'b1;

                unique case (req_reg.op)
                    OP_PUSH:
                    begin
                        if (full)
                            stat = STAT_FULL;
                        else
                            count_next = count_reg + CNT_W'(1);
                    end
                    OP_POP, OP_TYPE_POP:
                    begin
                        if (empty)
                            stat = STAT_EMPTY;
                        else if (hit)
                            count_next = count_reg - CNT_W'(1);
                        else
                            stat = STAT_NOMATCH;
                    end
                    OP_NOP:
                    begin
                        stat = STAT_DONE;
                    end
                    default:
                    begin
                        stat = STAT_DONE;
                    end
                endcase

                // front entry after the operation
                priority if (do_remove && seen[1])
                    front = entry[1].tag;
                else if (push_ok && empty)
                    front = req_reg.item_tag;
                else
                    front = entry[0].tag;

                result_next.status       = stat;
                result_next.removed_tag  = (do_remove && hit) ? removed[DEPTH].tag : '0;
                result_next.removed_type = (do_remove && hit) ? removed[DEPTH].kind : '0;
                result_next.occupancy    = OCC_W'(count_next);
                result_next.front_valid  = (count_next != '0);
                result_next.front_tag    = (count_next != '0) ? front : '0;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // checks
    a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC |=> done)
        else $error("execute cycle not followed by a result");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("transfer not followed by execute");

    a_front_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.front_valid == (count_reg != '0)))
        else $error("front valid disagrees with entry count");

endmodule
